// ----- rtl/mnhf_pkg.sv -----
`default_nettype none

package mnhf_pkg;

    // Configuration register widths and limits
    localparam int WIDTH_W     = 13;
    localparam int HEIGHT_W    = 12;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int WIDTH_LIMIT = 4096;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Input request kinds
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    // Input request payload
    typedef struct packed {
        op_t        op;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       occupied_in;
    } in_item_t;

    // Result payload
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       occupied_out;
        logic       newly_filled;
        logic       frame_end;
    } out_item_t;

    // One stored pixel word
    typedef struct packed {
        logic       occupied;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // Neighbour presence and flags for one fill evaluation
    typedef struct packed {
        logic north_ok;
        logic east_ok;
        logic south_ok;
        logic west_ok;
        logic last;
    } fill_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/mnhf_ram.sv -----
`default_nettype none

// Generic RAM: one write port, two registered read ports, read-first.
module mnhf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Reads return the old word on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mnhf_fill.sv -----
`default_nettype none

// Neighbour mean and fill decision for one pixel.
module mnhf_fill (
    input  wire mnhf_pkg::pix_t      centre,
    input  wire mnhf_pkg::pix_t      north,
    input  wire mnhf_pkg::pix_t      south,
    input  wire mnhf_pkg::pix_t      west,
    input  wire mnhf_pkg::pix_t      east,
    input  wire mnhf_pkg::fill_ctl_t ctl,
    output mnhf_pkg::out_item_t      result
);

    // Rounded mean of n values summing to s; thirds via reciprocal 10923 / 2^16
    function automatic logic [7:0] mean_of(input logic [9:0] s, input logic [2:0] n);
        logic [10:0] x;
        logic [24:0] p;
        logic [10:0] t2;
        logic [10:0] t4;
        logic [7:0]  m;
        x  = {s, 1'b0} + 11'd3;
        p  = 25'(x) * 25'd10923;
        t2 = {1'b0, s} + 11'd1;
        t4 = {1'b0, s} + 11'd2;
        case (n)
            3'd1:    m = s[7:0];
            3'd2:    m = t2[8:1];
            3'd3:    m = p[23:16];
            default: m = t4[9:2];
        endcase
        return m;
    endfunction

    logic       use_n, use_e, use_s, use_w;
    logic [2:0] cnt;
    logic [9:0] sum_r, sum_g, sum_b;

    // Present and occupied neighbours
    assign use_n = ctl.north_ok && north.occupied;
    assign use_e = ctl.east_ok  && east.occupied;
    assign use_s = ctl.south_ok && south.occupied;
    assign use_w = ctl.west_ok  && west.occupied;

    assign cnt = 3'(use_n) + 3'(use_e) + 3'(use_s) + 3'(use_w);

    // Per-channel sums
    assign sum_r = (use_n ? 10'(north.red) : 10'd0) + (use_e ? 10'(east.red) : 10'd0)
                 + (use_s ? 10'(south.red) : 10'd0) + (use_w ? 10'(west.red) : 10'd0);
    assign sum_g = (use_n ? 10'(north.green) : 10'd0) + (use_e ? 10'(east.green) : 10'd0)
                 + (use_s ? 10'(south.green) : 10'd0) + (use_w ? 10'(west.green) : 10'd0);
    assign sum_b = (use_n ? 10'(north.blue) : 10'd0) + (use_e ? 10'(east.blue) : 10'd0)
                 + (use_s ? 10'(south.blue) : 10'd0) + (use_w ? 10'(west.blue) : 10'd0);

    // Empty pixel with a neighbour takes the mean, else passes through
    always_comb begin
        result.red_out      = centre.red;
        result.green_out    = centre.green;
        result.blue_out     = centre.blue;
        result.occupied_out = centre.occupied;
        result.newly_filled = 1'b0;
        result.frame_end    = ctl.last;
        if (!centre.occupied && (cnt != 3'd0)) begin
            result.red_out      = mean_of(sum_r, cnt);
            result.green_out    = mean_of(sum_g, cnt);
            result.blue_out     = mean_of(sum_b, cnt);
            result.occupied_out = 1'b1;
            result.newly_filled = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/masked_neighbor_hole_fill_unit.sv -----
// Channel   Ports                          Payload
// s_        s_valid / s_ready / s_data     mnhf_pkg::in_item_t  (pixel or flush)
// m_        m_valid / m_ready / m_data     mnhf_pkg::out_item_t (filled pixel)
// cfg_      cfg_we / cfg_index / cfg_data  image_width, image_height
//
// One request per cycle unless stalled; results pass the fill and output registers.
// The column store has one write and two read ports: north (or next column top)
// and west are read per request, centre and south come from a two-word window.
// Reset is synchronous, active low; the store itself is not cleared.
// A stalled result holds the fill stage, which in turn holds s_ready low.
`default_nettype none

module masked_neighbor_hole_fill_unit #(
    parameter int MAX_COLUMN_HEIGHT = 2048
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire mnhf_pkg::in_item_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output mnhf_pkg::out_item_t                      m_data,
    input  wire logic                                cfg_we,
    input  wire logic [mnhf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mnhf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int RW    = $clog2(MAX_COLUMN_HEIGHT);
    localparam int HW    = $clog2(MAX_COLUMN_HEIGHT + 1);
    localparam int CW    = (HW > mnhf_pkg::HEIGHT_W) ? HW : mnhf_pkg::HEIGHT_W;
    localparam int DEPTH = 2 * MAX_COLUMN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = mnhf_pkg::WIDTH_W;

    // Store slot of a row in the column of given parity
    function automatic logic [AW-1:0] slot_of(input logic par, input logic [RW-1:0] row);
        return par ? (AW'(MAX_COLUMN_HEIGHT) + AW'(row)) : AW'(row);
    endfunction

    logic [WW-1:0]                  width_reg;
    logic [mnhf_pkg::HEIGHT_W-1:0]  height_reg;
    logic [WW-1:0]                  in_col_reg, in_col_next;
    logic [RW-1:0]                  in_row_reg, in_row_next;
    logic [RW-1:0]                  out_row_reg, out_row_next;

    logic [WW-1:0] w_eff;
    logic [CW-1:0] h_wide;
    logic [HW-1:0] h_eff, h_last;

    logic                s1_valid_reg, s1_emit_reg, s1_adv_reg, s1_look_reg, s1_fwd_reg;
    mnhf_pkg::fill_ctl_t s1_ctl_reg;
    mnhf_pkg::pix_t      s1_east_reg;
    mnhf_pkg::pix_t      cur_reg, sou_reg;
    logic                m_valid_reg;
    mnhf_pkg::out_item_t m_data_reg;

    logic                accept, out_free, s1_go;
    logic                pix_ok, flush_ok, emit, look, fwd, row_last, flush_last;
    mnhf_pkg::fill_ctl_t ctl;
    mnhf_pkg::pix_t      word, ram_a, ram_b;
    mnhf_pkg::out_item_t fill_out;
    logic [AW-1:0]       ra_addr, rb_addr, wr_addr;
    logic [RW-1:0]       nrow_in, nrow_out;

    // Effective frame size, clamped
    always_comb begin
        h_wide = CW'(height_reg);
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (width_reg > WW'(mnhf_pkg::WIDTH_LIMIT)) begin
            w_eff = WW'(mnhf_pkg::WIDTH_LIMIT);
        end else begin
            w_eff = width_reg;
        end
        if (h_wide == '0) begin
            h_eff = HW'(1);
        end else if (h_wide > CW'(MAX_COLUMN_HEIGHT)) begin
            h_eff = HW'(MAX_COLUMN_HEIGHT);
        end else begin
            h_eff = HW'(h_wide);
        end
        h_last = h_eff - HW'(1);
    end

    // Handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s1_go    = !s1_valid_reg || !s1_emit_reg || out_free;
    assign s_ready  = s1_go;
    assign accept   = s_valid && s_ready;

    assign word = '{occupied: s_data.occupied_in, blue: s_data.blue_in,
                    green: s_data.green_in, red: s_data.red_in};

    // Request decode: store addresses and neighbour flags
    always_comb begin
        pix_ok     = (s_data.op == mnhf_pkg::OP_PIXEL) && (in_col_reg < w_eff);
        flush_ok   = (s_data.op == mnhf_pkg::OP_FLUSH) && (in_col_reg >= w_eff);
        row_last   = HW'(in_row_reg) == h_last;
        flush_last = HW'(out_row_reg) == h_last;
        nrow_in    = row_last ? '0 : in_row_reg + RW'(1);
        nrow_out   = flush_last ? '0 : out_row_reg + RW'(1);
        wr_addr    = slot_of(in_col_reg[0], in_row_reg);
        ctl        = '0;
        if (s_data.op == mnhf_pkg::OP_PIXEL) begin
            emit         = pix_ok && (in_col_reg != '0);
            look         = row_last;
            fwd          = row_last && (in_row_reg == '0);
            ctl.north_ok = !row_last;
            ctl.east_ok  = 1'b1;
            ctl.south_ok = in_row_reg != '0;
            ctl.west_ok  = in_col_reg > WW'(1);
            // Last row prefetches the top of the current column for the next one
            ra_addr      = row_last ? slot_of(in_col_reg[0], '0)
                                    : slot_of(!in_col_reg[0], nrow_in);
            rb_addr      = slot_of(in_col_reg[0], in_row_reg);
        end else begin
            emit         = flush_ok;
            look         = 1'b0;
            fwd          = 1'b0;
            ctl.north_ok = !flush_last;
            ctl.south_ok = out_row_reg != '0;
            ctl.west_ok  = w_eff > WW'(1);
            ctl.last     = flush_last;
            ra_addr      = slot_of(!w_eff[0], nrow_out);
            rb_addr      = slot_of(w_eff[0], out_row_reg);
        end
    end

    // Frame position counters
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_row_next = out_row_reg;
        if (cfg_we) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_row_next = '0;
        end else if (accept && pix_ok) begin
            in_row_next = nrow_in;
            if (row_last) begin
                in_col_next = in_col_reg + WW'(1);
            end
        end else if (accept && flush_ok) begin
            out_row_next = nrow_out;
            if (flush_last) begin
                in_col_next = '0;
                in_row_next = '0;
            end
        end
    end

    // Configuration registers and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WW'(1);
            height_reg  <= mnhf_pkg::HEIGHT_W'(1);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_row_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (mnhf_pkg::cfg_reg_t'(cfg_index))
                    mnhf_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WW-1:0];
                    mnhf_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[mnhf_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_row_reg <= out_row_next;
        end
    end

    // Two-column pixel store
    mnhf_ram #(
        .WIDTH ($bits(mnhf_pkg::pix_t)),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .we      (accept && pix_ok),
        .waddr   (wr_addr),
        .wdata   (word),
        .re      (accept),
        .raddr_a (ra_addr),
        .raddr_b (rb_addr),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // Fill stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_go) begin
            s1_valid_reg <= accept;
        end
    end

    // Fill stage payload
    always_ff @(posedge aclk) begin
        if (s1_go) begin
            s1_emit_reg <= emit;
            s1_adv_reg  <= pix_ok || flush_ok;
            s1_look_reg <= look;
            s1_fwd_reg  <= fwd;
            s1_ctl_reg  <= ctl;
            s1_east_reg <= word;
        end
    end

    // Centre/south window slides down the column
    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_go && s1_adv_reg) begin
            if (s1_look_reg) begin
                cur_reg <= s1_fwd_reg ? s1_east_reg : ram_a;
            end else begin
                sou_reg <= cur_reg;
                cur_reg <= ram_a;
            end
        end
    end

    mnhf_fill u_fill (
        .centre (cur_reg),
        .north  (ram_a),
        .south  (sou_reg),
        .west   (ram_b),
        .east   (s1_east_reg),
        .ctl    (s1_ctl_reg),
        .result (fill_out)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_valid_reg && s1_emit_reg && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_emit_reg && out_free) begin
            m_data_reg <= fill_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_fill_sets_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_data_reg.newly_filled || m_data_reg.occupied_out))
        else $error("newly filled pixel not marked occupied");

    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && flush_ok && flush_last && !cfg_we)
        |=> (in_col_reg == '0 && in_row_reg == '0 && out_row_reg == '0))
        else $error("counters not cleared after last flush");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_ctl_reg)))
        else $error("fill stage moved while stalled");

    a_no_store_write_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && pix_ok) |-> (in_col_reg < w_eff))
        else $error("store written after frame complete");

    a_forward_single_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_look_reg && s1_fwd_reg) |-> (h_eff == HW'(1)))
        else $error("forward taken with more than one row");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_masked_neighbor_hole_fill_unit.sv -----
`timescale 1ns / 100ps

module tb_masked_neighbor_hole_fill_unit;

    localparam int COL_DEPTH      = 2048;
    localparam int CFG_W          = mnhf_pkg::CFG_DATA_W;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 30;
    localparam int RANDOM_ITEMS   = 500;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    mnhf_pkg::in_item_t     s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    mnhf_pkg::out_item_t    m_data;
    logic                   cfg_we    = 1'b0;
    mnhf_pkg::cfg_reg_t     cfg_index = mnhf_pkg::REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]       cfg_data  = '0;

    // Requests waiting for the driver, results waiting for the block
    mnhf_pkg::in_item_t    pending_reqs [$];
    mnhf_pkg::out_item_t   fill_expected [$];

    // Shadow of the block: registers, pixel store and stream position
    mnhf_pkg::pix_t tex_store [0:2*COL_DEPTH-1];
    int unsigned cfg_width_q  = 1;
    int unsigned cfg_height_q = 1;
    int unsigned in_row_q     = 0;
    int unsigned in_col_q     = 0;
    int unsigned out_row_q    = 0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned send_gap      = 0;
    int unsigned recv_gap      = 0;
    int unsigned hold_cnt      = 0;
    bit          hold_req      = 1'b0;
    bit          hold_done     = 1'b0;
    int unsigned quiet_cycles  = 0;
    int unsigned fail_count    = 0;
    int unsigned useful_items  = 0;

    masked_neighbor_hole_fill_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Queue tails for requests and expected results
    function automatic void add_req(mnhf_pkg::in_item_t req);
        pending_reqs.insert(pending_reqs.size(), req);
    endfunction

    function automatic void add_expect(mnhf_pkg::out_item_t res);
        fill_expected.insert(fill_expected.size(), res);
    endfunction

    // Effective frame size after clamping
    function automatic int unsigned used_width();
        if (cfg_width_q < 1) return 1;
        if (cfg_width_q > mnhf_pkg::WIDTH_LIMIT) return mnhf_pkg::WIDTH_LIMIT;
        return cfg_width_q;
    endfunction

    function automatic int unsigned used_height();
        if (cfg_height_q < 1) return 1;
        if (cfg_height_q > COL_DEPTH) return COL_DEPTH;
        return cfg_height_q;
    endfunction

    function automatic int unsigned store_slot(int unsigned col, int unsigned row);
        return (col & 1) * COL_DEPTH + (row % COL_DEPTH);
    endfunction

    // Rounded mean of n neighbours; thirds round half up, no tie possible
    function automatic logic [7:0] channel_mean(int unsigned sum, int unsigned n);
        case (n)
            1:       return 8'(sum);
            2:       return 8'((sum + 1) >> 1);
            3:       return 8'((2 * sum + 3) / 6);
            default: return 8'((sum + 2) >> 2);
        endcase
    endfunction

    // Result for pixel (col,row); east comes from the incoming request if present
    function automatic mnhf_pkg::out_item_t fill_pixel(int unsigned col, int unsigned row,
                                                       bit east_ok, mnhf_pkg::pix_t east,
                                                       int unsigned h);
        mnhf_pkg::pix_t      centre;
        mnhf_pkg::pix_t      nb [4];
        bit                  nb_ok [4];
        int unsigned         sum_r, sum_g, sum_b, n, k;
        mnhf_pkg::out_item_t res;
        centre   = tex_store[store_slot(col, row)];
        nb[0]    = tex_store[store_slot(col, row + 1)];
        nb_ok[0] = (row + 1 < h);
        nb[1]    = east;
        nb_ok[1] = east_ok;
        nb[2]    = tex_store[store_slot(col, row - 1)];
        nb_ok[2] = (row > 0);
        nb[3]    = tex_store[store_slot(col - 1, row)];
        nb_ok[3] = (col > 0);
        res.red_out      = centre.red;
        res.green_out    = centre.green;
        res.blue_out     = centre.blue;
        res.occupied_out = centre.occupied;
        res.newly_filled = 1'b0;
        res.frame_end    = 1'b0;
        if (!centre.occupied) begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            n     = 0;
            for (k = 0; k < 4; k++) begin
                if (nb_ok[k] && nb[k].occupied) begin
                    sum_r += nb[k].red;
                    sum_g += nb[k].green;
                    sum_b += nb[k].blue;
                    n++;
                end
            end
            if (n != 0) begin
                res.red_out      = channel_mean(sum_r, n);
                res.green_out    = channel_mean(sum_g, n);
                res.blue_out     = channel_mean(sum_b, n);
                res.occupied_out = 1'b1;
                res.newly_filled = 1'b1;
            end
        end
        return res;
    endfunction

    // Advances the shadow by one accepted request and queues its result, if any
    function automatic void predict_fill(mnhf_pkg::in_item_t req);
        int unsigned         w, h;
        mnhf_pkg::pix_t      word;
        mnhf_pkg::out_item_t res;
        w = used_width();
        h = used_height();
        if (req.op == mnhf_pkg::OP_PIXEL) begin
            // pixels beyond a complete frame are dropped until it is drained
            if (in_col_q >= w || in_row_q >= h) return;
            word = {req.occupied_in, req.blue_in, req.green_in, req.red_in};
            if (in_col_q > 0) begin
                add_expect(fill_pixel(in_col_q - 1, in_row_q, 1'b1, word, h));
                out_row_q++;
                if (out_row_q >= h) out_row_q = 0;
            end
            tex_store[store_slot(in_col_q, in_row_q)] = word;
            in_row_q++;
            if (in_row_q >= h) begin
                in_row_q = 0;
                in_col_q++;
            end
        end else begin
            // flush only counts once the last pixel is in
            if (in_col_q < w || out_row_q >= h) return;
            res = fill_pixel(w - 1, out_row_q, 1'b0, '0, h);
            out_row_q++;
            if (out_row_q >= h) begin
                res.frame_end = 1'b1;
                in_row_q  = 0;
                in_col_q  = 0;
                out_row_q = 0;
            end
            add_expect(res);
        end
    endfunction

    function automatic mnhf_pkg::in_item_t make_req(mnhf_pkg::op_t kind, logic [7:0] r,
                                                    logic [7:0] g, logic [7:0] b,
                                                    logic occ);
        mnhf_pkg::in_item_t req;
        req = {kind, r, g, b, occ};
        return req;
    endfunction

    function automatic mnhf_pkg::in_item_t flush_req();
        return make_req(mnhf_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0);
    endfunction

    // Channel values leaning towards the extremes
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic mnhf_pkg::in_item_t rand_pixel(int unsigned occ_pct);
        return make_req(mnhf_pkg::OP_PIXEL, rand_chan(), rand_chan(), rand_chan(),
                        $urandom_range(0, 99) < occ_pct);
    endfunction

    function automatic int unsigned pick_extent(int unsigned top);
        case ($urandom_range(0, 19))
            0:             return $urandom_range(1, top);
            1, 2, 3, 4, 5: return $urandom_range(6, 16);
            default:       return $urandom_range(1, 5);
        endcase
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 15;
            default: return 35;
        endcase
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Block is quiet: nothing queued, nothing offered, nothing owed; checked again
    // after the settle so a request handed over at the last edge is not missed
    task automatic wait_idle();
        do begin
            while (pending_reqs.size() != 0 || s_valid || fill_expected.size() != 0)
                @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end while (pending_reqs.size() != 0 || s_valid || fill_expected.size() != 0);
    endtask

    task automatic write_setting(mnhf_pkg::cfg_reg_t idx, int unsigned val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        // a write restarts the frame
        if (idx == mnhf_pkg::REG_IMAGE_WIDTH) cfg_width_q = val & 32'h1FFF;
        else cfg_height_q = val & 32'hFFF;
        in_row_q  = 0;
        in_col_q  = 0;
        out_row_q = 0;
    endtask

    // One frame of pixels and flushes with some ignored requests mixed in;
    // a cut frame stops anywhere short of its end
    task automatic queue_frame(int unsigned cols, int unsigned rows, int unsigned occ_pct,
                               bit cut_short);
        int unsigned total, stop_at, k;
        total   = cols * rows + rows;
        stop_at = total;
        if (cut_short && total > 1) stop_at = $urandom_range(1, total - 1);
        for (k = 0; k < stop_at; k++) begin
            if (k < cols * rows) begin
                if ($urandom_range(0, 99) < 2)
                    add_req(flush_req());
                add_req(rand_pixel(occ_pct));
            end else begin
                if (k == cols * rows && $urandom_range(0, 4) == 0)
                    add_req(rand_pixel(50));
                add_req(flush_req());
            end
            useful_items++;
        end
        if (!cut_short && $urandom_range(0, 4) == 0)
            add_req(flush_req());
    endtask

    // Request driver
    always @(posedge aclk) begin : drive_requests
        logic busy;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                predict_fill(s_data);
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_reqs.size() != 0 &&
                             $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap <= $urandom_range(0, 11);
                    s_valid  <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    s_data  <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge aclk) begin : watch_results
        mnhf_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_gap  <= 0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (fill_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %h",
                                 $time, m_data);
                end else begin
                    want = fill_expected.pop_front();
                    check_field("red_out", want.red_out, m_data.red_out);
                    check_field("green_out", want.green_out, m_data.green_out);
                    check_field("blue_out", want.blue_out, m_data.blue_out);
                    check_field("occupied_out", want.occupied_out, m_data.occupied_out);
                    check_field("newly_filled", want.newly_filled, m_data.newly_filled);
                    check_field("frame_end", want.frame_end, m_data.frame_end);
                end
            end
            // one long hold-off so the pipeline backs up into s_ready
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_cnt  <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready  <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else if ($urandom_range(0, 99) < recv_idle_pct) begin
                recv_gap <= $urandom_range(0, 11);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned w, h, k, n_frames, occ, col, row, base;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 15;
        recv_idle_pct = 15;

        // Reset size 1x1: early flush, one pixel, late pixel, drain, stray flush
        add_req(flush_req());
        add_req(make_req(mnhf_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'hFF, 1'b0));
        add_req(make_req(mnhf_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h00, 1'b1));
        add_req(flush_req());
        add_req(flush_req());

        // Zero sizes clamp up to 1
        write_setting(mnhf_pkg::REG_IMAGE_WIDTH, 0);
        write_setting(mnhf_pkg::REG_IMAGE_HEIGHT, 0);
        add_req(make_req(mnhf_pkg::OP_PIXEL, 8'hA5, 8'h5A, 8'hFF, 1'b1));
        add_req(flush_req());

        // 3x3 checkerboard: white cross around an empty centre, empty corners
        write_setting(mnhf_pkg::REG_IMAGE_WIDTH, 3);
        write_setting(mnhf_pkg::REG_IMAGE_HEIGHT, 3);
        add_req(flush_req());
        for (col = 0; col < 3; col++)
            for (row = 0; row < 3; row++)
                if ((col + row) % 2 == 1)
                    add_req(make_req(mnhf_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1));
                else
                    add_req(rand_pixel(0));
        add_req(rand_pixel(100));
        for (row = 0; row < 3; row++)
            add_req(flush_req());

        // Widest setting, one row high: a run of pixels, then the frame is abandoned
        send_idle_pct = 5;
        recv_idle_pct = 5;
        write_setting(mnhf_pkg::REG_IMAGE_WIDTH, 8191);
        write_setting(mnhf_pkg::REG_IMAGE_HEIGHT, 1);
        for (k = 0; k < 120; k++) add_req(rand_pixel(50));

        // Tall two-column frame
        write_setting(mnhf_pkg::REG_IMAGE_WIDTH, 2);
        write_setting(mnhf_pkg::REG_IMAGE_HEIGHT, 90);
        queue_frame(2, 90, 50, 1'b0);

        // Long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 10;
        write_setting(mnhf_pkg::REG_IMAGE_WIDTH, 6);
        write_setting(mnhf_pkg::REG_IMAGE_HEIGHT, 10);
        hold_req = 1'b1;
        queue_frame(6, 10, 50, 1'b0);

        // Sender stops mid-frame until every result is in, then carries on
        send_idle_pct = 10;
        wait_idle();
        for (k = 0; k < 30; k++) add_req(rand_pixel(40));
        wait_idle();
        for (k = 30; k < 60; k++) add_req(rand_pixel(40));
        for (k = 0; k < 10; k++)
            add_req(flush_req());

        // Random frames: mostly complete, some back to back, some abandoned
        base = useful_items;
        while (useful_items - base < RANDOM_ITEMS) begin
            w = pick_extent(24);
            h = pick_extent(24);
            if ($urandom_range(0, 1) == 0) begin
                write_setting(mnhf_pkg::REG_IMAGE_WIDTH, w);
                write_setting(mnhf_pkg::REG_IMAGE_HEIGHT, h);
            end else begin
                write_setting(mnhf_pkg::REG_IMAGE_HEIGHT, h);
                write_setting(mnhf_pkg::REG_IMAGE_WIDTH, w);
            end
            send_idle_pct = pick_idle_pct();
            recv_idle_pct = pick_idle_pct();
            n_frames = $urandom_range(1, 3);
            for (k = 0; k < n_frames; k++) begin
                occ = $urandom_range(0, 4) * 25;
                queue_frame(w, h, occ, k == n_frames - 1 && $urandom_range(0, 6) == 0);
            end
        end

        // Closing stretch at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < 3; k++) begin
            w = $urandom_range(2, 6);
            h = $urandom_range(2, 8);
            write_setting(mnhf_pkg::REG_IMAGE_WIDTH, w);
            write_setting(mnhf_pkg::REG_IMAGE_HEIGHT, h);
            queue_frame(w, h, 50, 1'b0);
            queue_frame(w, h, 25, 1'b0);
        end

        wait_idle();
        if (fail_count == 0 && fill_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
